// ===== sv/smx_pkg.sv =====
package smx_pkg;

   localparam int DATA_DEPTH_DEF = 256;
   localparam int CALL_DEPTH_DEF = 64;
   localparam int PROG_SIZE_DEF  = 65536;
   localparam int WORD_W         = 32;
   localparam int ADDR_W         = 16;
   localparam int OPC_W          = 8;
   localparam int STAT_W         = 4;

   typedef enum logic [OPC_W-1:0] {
      OP_PUSH  = 8'd0,
      OP_POP   = 8'd1,
      OP_HALT  = 8'd2,
      OP_ADD   = 8'd3,
      OP_SUB   = 8'd4,
      OP_MUL   = 8'd5,
      OP_DIV   = 8'd6,
      OP_MOD   = 8'd7,
      OP_DUP   = 8'd8,
      OP_SWAP  = 8'd9,
      OP_AND   = 8'd10,
      OP_OR    = 8'd11,
      OP_XOR   = 8'd12,
      OP_NOT   = 8'd13,
      OP_EQU   = 8'd14,
      OP_NEQU  = 8'd15,
      OP_CALL  = 8'd16,
      OP_ACALL = 8'd17,
      OP_RET   = 8'd18,
      OP_JMP   = 8'd19,
      OP_JNZ   = 8'd20
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 4'd0,
      ST_HALT    = 4'd1,
      ST_BADOP   = 4'd2,
      ST_ADDR    = 4'd3,
      ST_DUNDER  = 4'd4,
      ST_DOVER   = 4'd5,
      ST_RUNDER  = 4'd6,
      ST_ROVER   = 4'd7,
      ST_DIVZERO = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      CL_BINARY,
      CL_UNARY,
      CL_FLOW,
      CL_OTHER
   } class_type;

   typedef struct packed {
      logic [OPC_W-1:0]  opcode;
      logic [WORD_W-1:0] operand;
      class_type         cls;
      logic              valid_op;
   } instr_type;

   typedef enum logic [3:0] {
      EX_IDLE,
      EX_READ,
      EX_READ2,
      EX_EXEC,
      EX_DIV,
      EX_WRITE2,
      EX_RESP
   } ex_state_type;

endpackage

// ===== sv/smx_ram.sv =====
module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== sv/smx_front.sv =====
module smx_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [smx_pkg::OPC_W-1:0]  req_opcode,
   input  logic signed [smx_pkg::WORD_W-1:0] req_operand,
   output logic                       q_valid,
   input  logic                       q_pop,
   output smx_pkg::instr_type         q_data
);
   import smx_pkg::*;

   instr_type slot_ff [2];
   instr_type cur;
   logic      rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push;

   always_comb begin
      cur.opcode   = req_opcode;
      cur.operand  = req_operand;
      cur.valid_op = (req_opcode <= OP_JNZ);
      case (req_opcode) inside
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR, OP_EQU,
         OP_NEQU, OP_SWAP:
            cur.cls = CL_BINARY;
         OP_POP, OP_DUP, OP_NOT, OP_JNZ:
            cur.cls = CL_UNARY;
         OP_CALL, OP_ACALL, OP_RET, OP_JMP:
            cur.cls = CL_FLOW;
         default:
            cur.cls = CL_OTHER;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      wr_ptr_in = wr_ptr_ff ^ push;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cur;
      end
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !req_ready)
      else $error("accept while queue full");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !q_valid)
      else $error("queue valid while empty");
endmodule

// ===== sv/smx_div.sv =====
module smx_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [smx_pkg::WORD_W-1:0]  dividend,
   input  logic [smx_pkg::WORD_W-1:0]  divisor,
   output logic                        done,
   output logic [smx_pkg::WORD_W-1:0]  quot,
   output logic [smx_pkg::WORD_W-1:0]  rem
);
   import smx_pkg::*;

   localparam int CW = $clog2(WORD_W + 1);

   logic [WORD_W-1:0] q_ff, q_in, d_ff, d_in;
   logic [WORD_W:0]   r_ff, r_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in, qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [WORD_W:0]   shifted, diff;

   always_comb begin
      shifted = {r_ff[WORD_W-1:0], q_ff[WORD_W-1]};
      diff    = shifted - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      if (start) begin
         q_in    = dividend[WORD_W-1] ? -dividend : dividend;
         d_in    = divisor[WORD_W-1] ? -divisor : divisor;
         r_in    = '0;
         cnt_in  = CW'(WORD_W);
         busy_in = 1'b1;
         qneg_in = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         rneg_in = dividend[WORD_W-1];
      end else if (busy_ff) begin
         if (!diff[WORD_W]) begin
            r_in = diff;
            q_in = {q_ff[WORD_W-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   assign done = busy_ff && (cnt_ff == CW'(1));
   assign quot = qneg_ff ? -q_in : q_in;
   assign rem  = rneg_ff ? -r_in[WORD_W-1:0] : r_in[WORD_W-1:0];

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end
endmodule

// ===== sv/smx_back.sv =====
module smx_back #(
   parameter int DATA_DEPTH = smx_pkg::DATA_DEPTH_DEF,
   parameter int CALL_DEPTH = smx_pkg::CALL_DEPTH_DEF,
   parameter int PROG_SIZE  = smx_pkg::PROG_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  smx_pkg::instr_type          q_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [smx_pkg::ADDR_W-1:0]  rsp_next_addr,
   output logic signed [smx_pkg::WORD_W-1:0] rsp_top_value,
   output logic [8:0]                  rsp_depth,
   output logic                        rsp_halted,
   output logic [smx_pkg::STAT_W-1:0]  rsp_status
);
   import smx_pkg::*;

   localparam int DAW = $clog2(DATA_DEPTH);
   localparam int DDW = $clog2(DATA_DEPTH + 1);
   localparam int CAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
   localparam int CDW = $clog2(CALL_DEPTH + 1);
   localparam int XW  = WORD_W + 2;

   ex_state_type state_ff, state_in;
   instr_type    ins_ff, ins_in;
   logic [DDW-1:0]   dd_ff, dd_in;
   logic [CDW-1:0]   rd_ff, rd_in;
   logic [ADDR_W-1:0] ip_ff, ip_in;
   logic             stop_ff, stop_in;
   status_type       code_ff, code_in;
   logic [WORD_W-1:0] a_ff, a_in, b_ff, b_in, top_ff, top_in, res_ff, res_in;

   logic            dwe, cwe;
   logic [DAW-1:0]  dwa, dra;
   logic [WORD_W-1:0] dwd, drd;
   logic [CAW-1:0]  cwa, cra;
   logic [ADDR_W-1:0] crd;
   logic            div_start, div_done;
   logic [WORD_W-1:0] div_q, div_r;

   logic signed [XW-1:0] ipx, nextx, relx;
   logic addr_ok, rel_ok, abs_ok, ret_ok;

   smx_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH)) u_dram (
      .clock(clock), .wr_en(dwe), .wr_addr(dwa), .wr_data(dwd),
      .rd_addr(dra), .rd_data(drd));

   smx_ram #(.WIDTH(ADDR_W), .DEPTH(CALL_DEPTH)) u_cram (
      .clock(clock), .wr_en(cwe), .wr_addr(cwa), .wr_data(ip_ff),
      .rd_addr(cra), .rd_data(crd));

   smx_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(b_ff),
      .divisor(a_ff), .done(div_done), .quot(div_q), .rem(div_r));

   always_comb begin
      ipx     = XW'($signed({1'b0, ip_ff}));
      nextx   = ipx + XW'(1);
      relx    = ipx + XW'($signed(ins_ff.operand));
      addr_ok = (nextx < XW'(PROG_SIZE));
      rel_ok  = (relx >= 0) && (relx < XW'(PROG_SIZE));
      abs_ok  = !ins_ff.operand[WORD_W-1] &&
                ($signed(ins_ff.operand) < $signed(WORD_W'(PROG_SIZE)));
      ret_ok  = ({1'b0, crd} + 17'd1) < 17'(PROG_SIZE);
   end

   always_comb begin
      dra = DAW'(dd_ff - DDW'(1));
      if (state_ff == EX_READ) begin
         dra = DAW'(dd_ff - DDW'(2));
      end
      cra = CAW'(rd_ff - CDW'(1));
   end

   always_comb begin
      state_in  = state_ff;
      ins_in    = ins_ff;
      dd_in     = dd_ff;
      rd_in     = rd_ff;
      ip_in     = ip_ff;
      stop_in   = stop_ff;
      code_in   = code_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      top_in    = top_ff;
      res_in    = res_ff;
      dwe       = 1'b0;
      dwa       = DAW'(dd_ff);
      dwd       = ins_ff.operand;
      cwe       = 1'b0;
      cwa       = CAW'(rd_ff);
      div_start = 1'b0;
      q_pop     = 1'b0;
      case (state_ff)
         EX_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               ins_in = q_data;
               if (stop_ff) begin
                  state_in = EX_RESP;
               end else begin
                  state_in = EX_READ;
               end
            end
         end
         EX_READ: begin
            a_in     = drd;
            state_in = EX_READ2;
         end
         EX_READ2: begin
            b_in     = drd;
            state_in = EX_EXEC;
         end
         EX_EXEC: begin
            state_in = EX_RESP;
            case (ins_ff.opcode)
               OP_PUSH: begin
                  if (dd_ff >= DDW'(DATA_DEPTH)) begin
                     stop_in = 1'b1; code_in = ST_DOVER;
                  end else if (!addr_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else begin
                     dwe = 1'b1; dd_in = dd_ff + DDW'(1);
                     top_in = ins_ff.operand; ip_in = ADDR_W'(nextx);
                  end
               end
               OP_POP: begin
                  if (dd_ff == '0) begin
                     stop_in = 1'b1; code_in = ST_DUNDER;
                  end else if (!addr_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else begin
                     dd_in = dd_ff - DDW'(1); top_in = b_ff;
                     ip_in = ADDR_W'(nextx);
                  end
               end
               OP_HALT: begin
                  stop_in = 1'b1; code_in = ST_HALT;
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
               OP_EQU, OP_NEQU: begin
                  if (!addr_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else if (dd_ff < DDW'(2)) begin
                     ip_in = ADDR_W'(nextx);
                  end else if ((ins_ff.opcode == OP_DIV || ins_ff.opcode == OP_MOD)
                               && a_ff == '0) begin
                     stop_in = 1'b1; code_in = ST_DIVZERO;
                  end else begin
                     case (ins_ff.opcode)
                        OP_ADD:  res_in = b_ff + a_ff;
                        OP_SUB:  res_in = b_ff - a_ff;
                        OP_AND:  res_in = a_ff & b_ff;
                        OP_OR:   res_in = a_ff | b_ff;
                        OP_XOR:  res_in = a_ff ^ b_ff;
                        OP_EQU:  res_in = WORD_W'(a_ff == b_ff);
                        OP_NEQU: res_in = WORD_W'(a_ff != b_ff);
                        default: res_in = a_ff;
                     endcase
                     if (ins_ff.opcode == OP_DIV || ins_ff.opcode == OP_MOD ||
                         ins_ff.opcode == OP_MUL) begin
                        div_start = (ins_ff.opcode != OP_MUL);
                        state_in  = EX_DIV;
                     end else begin
                        dwe = 1'b1; dwa = DAW'(dd_ff - DDW'(2)); dwd = res_in;
                        dd_in = dd_ff - DDW'(1); top_in = res_in;
                        ip_in = ADDR_W'(nextx);
                     end
                  end
               end
               OP_DUP: begin
                  if (dd_ff == '0) begin
                     stop_in = 1'b1; code_in = ST_DUNDER;
                  end else if (dd_ff >= DDW'(DATA_DEPTH)) begin
                     stop_in = 1'b1; code_in = ST_DOVER;
                  end else if (!addr_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else begin
                     dwe = 1'b1; dwd = a_ff; dd_in = dd_ff + DDW'(1);
                     ip_in = ADDR_W'(nextx);
                  end
               end
               OP_SWAP: begin
                  if (dd_ff < DDW'(2)) begin
                     stop_in = 1'b1; code_in = ST_DUNDER;
                  end else if (!addr_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else begin
                     dwe = 1'b1; dwa = DAW'(dd_ff - DDW'(1)); dwd = b_ff;
                     top_in = b_ff; ip_in = ADDR_W'(nextx);
                     state_in = EX_WRITE2;
                  end
               end
               OP_NOT: begin
                  if (dd_ff == '0) begin
                     stop_in = 1'b1; code_in = ST_DUNDER;
                  end else if (!addr_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else begin
                     dwe = 1'b1; dwa = DAW'(dd_ff - DDW'(1)); dwd = ~a_ff;
                     top_in = ~a_ff; ip_in = ADDR_W'(nextx);
                  end
               end
               OP_CALL, OP_ACALL: begin
                  if (rd_ff >= CDW'(CALL_DEPTH)) begin
                     stop_in = 1'b1; code_in = ST_ROVER;
                  end else if ((ins_ff.opcode == OP_CALL) ? !rel_ok : !abs_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else begin
                     cwe = 1'b1; rd_in = rd_ff + CDW'(1);
                     ip_in = (ins_ff.opcode == OP_CALL) ? ADDR_W'(relx)
                                                         : ins_ff.operand[ADDR_W-1:0];
                  end
               end
               OP_RET: begin
                  if (rd_ff == '0) begin
                     stop_in = 1'b1; code_in = ST_RUNDER;
                  end else if (!ret_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else begin
                     rd_in = rd_ff - CDW'(1); ip_in = crd + ADDR_W'(1);
                  end
               end
               OP_JMP: begin
                  if (!rel_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else begin
                     ip_in = ADDR_W'(relx);
                  end
               end
               OP_JNZ: begin
                  if (dd_ff == '0) begin
                     stop_in = 1'b1; code_in = ST_DUNDER;
                  end else if ((a_ff != '0) ? !rel_ok : !addr_ok) begin
                     stop_in = 1'b1; code_in = ST_ADDR;
                  end else begin
                     ip_in = (a_ff != '0) ? ADDR_W'(relx) : ADDR_W'(nextx);
                     dd_in = dd_ff - DDW'(1); top_in = b_ff;
                  end
               end
               default: begin
                  stop_in = 1'b1; code_in = ST_BADOP;
               end
            endcase
         end
         EX_DIV: begin
            if (ins_ff.opcode == OP_MUL || div_done) begin
               case (ins_ff.opcode)
                  OP_MUL:  res_in = WORD_W'(a_ff * b_ff);
                  OP_DIV:  res_in = div_q;
                  default: res_in = div_r;
               endcase
               dwe = 1'b1; dwa = DAW'(dd_ff - DDW'(2)); dwd = res_in;
               dd_in = dd_ff - DDW'(1); top_in = res_in;
               ip_in = ADDR_W'(nextx);
               state_in = EX_RESP;
            end
         end
         EX_WRITE2: begin
            dwe = 1'b1; dwa = DAW'(dd_ff - DDW'(2)); dwd = a_ff;
            state_in = EX_RESP;
         end
         EX_RESP: begin
            if (rsp_ready) begin
               state_in = EX_IDLE;
            end
         end
         default: state_in = EX_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid     = (state_ff == EX_RESP);
      rsp_next_addr = ip_ff;
      rsp_top_value = (dd_ff == '0) ? '0 : top_ff;
      rsp_depth     = 9'(dd_ff);
      rsp_halted    = stop_ff;
      rsp_status    = code_ff;
   end

   always_ff @(posedge clock) begin
      ins_ff <= ins_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      if (reset) begin
         state_ff <= EX_IDLE;
         dd_ff    <= '0;
         rd_ff    <= '0;
         ip_ff    <= '0;
         stop_ff  <= 1'b0;
         code_ff  <= ST_OK;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         dd_ff    <= dd_in;
         rd_ff    <= rd_in;
         ip_ff    <= ip_in;
         stop_ff  <= stop_in;
         code_ff  <= code_in;
         top_ff   <= top_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) dd_ff <= DDW'(DATA_DEPTH))
      else $error("data depth beyond capacity");
   assert property (@(posedge clock) disable iff (reset) rd_ff <= CDW'(CALL_DEPTH))
      else $error("call depth beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      $past(stop_ff) && !$past(reset) |-> stop_ff && $stable(ip_ff) && $stable(dd_ff))
      else $error("state changed after halt");
   assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> code_ff != ST_OK)
      else $error("halt without status");
endmodule

// ===== sv/stack_machine_execute_step_top.sv =====
// Steps per request: pop from the queue, read top, read next, execute, respond; swap adds a
// second write state, mul adds a result state, and div and mod wait in that state for the
// shift-subtract divider. A new request is popped only after the response is taken;
// after a stop, a popped request goes straight to the response.
// A two-entry queue lets the front accept ahead of execution.
// Reset: synchronous; clears depths, address, halt flag and status; stack RAMs are not cleared.
module stack_machine_execute_step_top #(
   parameter int DATA_DEPTH = smx_pkg::DATA_DEPTH_DEF,
   parameter int CALL_DEPTH = smx_pkg::CALL_DEPTH_DEF,
   parameter int PROG_SIZE  = smx_pkg::PROG_SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [smx_pkg::OPC_W-1:0]  req_opcode,
   input  logic signed [smx_pkg::WORD_W-1:0] req_operand,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [smx_pkg::ADDR_W-1:0] rsp_next_addr,
   output logic signed [smx_pkg::WORD_W-1:0] rsp_top_value,
   output logic [8:0]                 rsp_depth,
   output logic                       rsp_halted,
   output logic [smx_pkg::STAT_W-1:0] rsp_status
);
   import smx_pkg::*;

   logic      q_valid, q_pop;
   instr_type q_data;

   smx_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_operand(req_operand), .q_valid(q_valid),
      .q_pop(q_pop), .q_data(q_data));

   smx_back #(
      .DATA_DEPTH(DATA_DEPTH), .CALL_DEPTH(CALL_DEPTH), .PROG_SIZE(PROG_SIZE)
   ) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_data(q_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_next_addr(rsp_next_addr), .rsp_top_value(rsp_top_value),
      .rsp_depth(rsp_depth), .rsp_halted(rsp_halted), .rsp_status(rsp_status));
endmodule

// ===== test/smx_checker.sv =====
module smx_checker
   import smx_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [OPC_W-1:0]    req_opcode,
   input  logic [WORD_W-1:0]   req_operand,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [ADDR_W-1:0]   rsp_next_addr,
   input  logic [WORD_W-1:0]   rsp_top_value,
   input  logic [8:0]          rsp_depth,
   input  logic                rsp_halted,
   input  logic [STAT_W-1:0]   rsp_status,
   output int                  errors,
   output int                  pending,
   output int                  responses
);

   typedef struct {
      logic [ADDR_W-1:0] next_addr;
      logic [WORD_W-1:0] top_value;
      logic [8:0]        depth;
      logic              halted;
      logic [STAT_W-1:0] status;
   } step_result_type;

   logic [WORD_W-1:0] data_mem [DATA_DEPTH_DEF];
   logic [ADDR_W-1:0] call_mem [CALL_DEPTH_DEF];
   int                data_cnt;
   int                call_cnt;
   longint            pc;
   logic              stopped;
   logic [STAT_W-1:0] stop_code;
   step_result_type   step_results_q [$];

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s: got %h, want %h (response %0d)", field, got, want, responses);
      errors++;
   endtask

   function automatic logic addr_in_range(input longint t);
      return t >= 0 && t < PROG_SIZE_DEF;
   endfunction

   task automatic stop_machine(input status_type code);
      stopped   = 1'b1;
      stop_code = code;
   endtask

   task automatic execute(input logic [OPC_W-1:0] op, input logic [WORD_W-1:0] imm);
      longint            nxt;
      longint            off;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] r;
      nxt = pc + 1;
      off = longint'($signed(imm));
      case (op)
         OP_PUSH: begin
            if (data_cnt >= DATA_DEPTH_DEF) begin stop_machine(ST_DOVER); return; end
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
            data_mem[data_cnt] = imm;
            data_cnt++;
         end
         OP_POP: begin
            if (data_cnt == 0) begin stop_machine(ST_DUNDER); return; end
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
            data_cnt--;
         end
         OP_HALT: begin
            stop_machine(ST_HALT);
            return;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR, OP_EQU, OP_NEQU: begin
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
            if (data_cnt >= 2) begin
               a = data_mem[data_cnt-1];
               b = data_mem[data_cnt-2];
               if ((op == OP_DIV || op == OP_MOD) && a == 0) begin
                  stop_machine(ST_DIVZERO);
                  return;
               end
               case (op)
                  OP_ADD: r = a + b;
                  OP_SUB: r = b - a;
                  OP_MUL: r = a * b;
                  OP_DIV: r = (a == '1) ? -b
                            : WORD_W'(longint'($signed(b)) / longint'($signed(a)));
                  OP_MOD: r = (a == '1) ? '0
                            : WORD_W'(longint'($signed(b)) % longint'($signed(a)));
                  OP_AND: r = a & b;
                  OP_OR:  r = a | b;
                  OP_XOR: r = a ^ b;
                  OP_EQU: r = (a == b) ? 1 : 0;
                  default: r = (a != b) ? 1 : 0;
               endcase
               data_cnt--;
               data_mem[data_cnt-1] = r;
            end
         end
         OP_DUP: begin
            if (data_cnt == 0) begin stop_machine(ST_DUNDER); return; end
            if (data_cnt >= DATA_DEPTH_DEF) begin stop_machine(ST_DOVER); return; end
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
            data_mem[data_cnt] = data_mem[data_cnt-1];
            data_cnt++;
         end
         OP_SWAP: begin
            if (data_cnt < 2) begin stop_machine(ST_DUNDER); return; end
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
            a = data_mem[data_cnt-1];
            data_mem[data_cnt-1] = data_mem[data_cnt-2];
            data_mem[data_cnt-2] = a;
         end
         OP_NOT: begin
            if (data_cnt == 0) begin stop_machine(ST_DUNDER); return; end
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
            data_mem[data_cnt-1] = ~data_mem[data_cnt-1];
         end
         OP_CALL, OP_ACALL: begin
            if (call_cnt >= CALL_DEPTH_DEF) begin stop_machine(ST_ROVER); return; end
            nxt = (op == OP_CALL) ? pc + off : off;
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
            call_mem[call_cnt] = ADDR_W'(pc);
            call_cnt++;
         end
         OP_RET: begin
            if (call_cnt == 0) begin stop_machine(ST_RUNDER); return; end
            nxt = longint'(call_mem[call_cnt-1]) + 1;
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
            call_cnt--;
         end
         OP_JMP: begin
            nxt = pc + off;
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
         end
         OP_JNZ: begin
            if (data_cnt == 0) begin stop_machine(ST_DUNDER); return; end
            if (data_mem[data_cnt-1] != 0) nxt = pc + off;
            if (!addr_in_range(nxt)) begin stop_machine(ST_ADDR); return; end
            data_cnt--;
         end
         default: begin
            stop_machine(ST_BADOP);
            return;
         end
      endcase
      pc = nxt;
   endtask

   always @(posedge clock) begin
      step_result_type want;
      if (reset) begin
         data_cnt  = 0;
         call_cnt  = 0;
         pc        = 0;
         stopped   = 1'b0;
         stop_code = ST_OK;
         responses = 0;
         errors    = 0;
         step_results_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (step_results_q.size() == 0) begin
               report("unexpected response", '0, '0);
            end else begin
               want = step_results_q.pop_front();
               if (rsp_next_addr !== want.next_addr) report("next_addr", rsp_next_addr, want.next_addr);
               if (rsp_top_value !== want.top_value) report("top_value", rsp_top_value, want.top_value);
               if (rsp_depth !== want.depth) report("depth", rsp_depth, want.depth);
               if (rsp_halted !== want.halted) report("halted", rsp_halted, want.halted);
               if (rsp_status !== want.status) report("status", rsp_status, want.status);
            end
         end
         if (req_valid && req_ready) begin
            if (!stopped) execute(req_opcode, req_operand);
            want.next_addr = ADDR_W'(pc);
            want.top_value = (data_cnt > 0) ? data_mem[data_cnt-1] : '0;
            want.depth     = 9'(data_cnt);
            want.halted    = stopped;
            want.status    = stop_code;
            step_results_q.push_back(want);
         end
      end
      pending = step_results_q.size();
   end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   import smx_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [OPC_W-1:0]    req_opcode  = '0;
   logic [WORD_W-1:0]   req_operand = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [ADDR_W-1:0]   rsp_next_addr;
   logic [WORD_W-1:0]   rsp_top_value;
   logic [8:0]          rsp_depth;
   logic                rsp_halted;
   logic [STAT_W-1:0]   rsp_status;
   int                  errors;
   int                  pending;
   int                  responses;

   logic                quiet = 1'b0;
   int                  rsp_stall;
   int                  idle_cycles = 0;
   int                  sent = 0;
   int                  max_depth_seen = 0;
   int                  fault_pick;

   // shadow of the machine, enough to steer requests away from faults
   longint              g_pc = 0;
   int                  g_depth = 0;
   longint              g_calls [$];
   logic [WORD_W-1:0]   g_last_push = '0;

   always #4 clock = ~clock;

   stack_machine_execute_step_top dut (.*);

   smx_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_stall = quiet ? 0 : $urandom_range(0, 4);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send(input logic [OPC_W-1:0] op, input logic [WORD_W-1:0] val);
      int gap;
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_operand <= val;
      do @(posedge clock); while (!req_ready);
      sent++;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue(input opcode_type op, input logic [WORD_W-1:0] val);
      send(op, val);
      case (op)
         OP_PUSH: begin g_depth++; g_last_push = val; g_pc++; end
         OP_POP:  begin g_depth--; g_pc++; end
         OP_DUP:  begin g_depth++; g_pc++; end
         OP_CALL: begin g_calls.push_back(g_pc); g_pc = g_pc + longint'($signed(val)); end
         OP_ACALL: begin g_calls.push_back(g_pc); g_pc = longint'($signed(val)); end
         OP_RET:  g_pc = g_calls.pop_back() + 1;
         OP_JMP:  g_pc = g_pc + longint'($signed(val));
         OP_JNZ: begin
            g_depth--;
            g_pc = (g_last_push != 0) ? g_pc + longint'($signed(val)) : g_pc + 1;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR, OP_EQU, OP_NEQU: begin
            if (g_depth >= 2) g_depth--;
            g_pc++;
         end
         default: g_pc++;
      endcase
      if (g_depth > max_depth_seen) max_depth_seen = g_depth;
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0;
         4: return WORD_W'($urandom_range(0, 20));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] rel_target();
      return WORD_W'(longint'($urandom_range(0, 60000)) - g_pc);
   endfunction

   task automatic push_or_pop();
      if (g_depth < 200 || g_depth == 0) issue(OP_PUSH, rand_word());
      else issue(OP_POP, rand_word());
   endtask

   task automatic random_step();
      int               r;
      logic [WORD_W-1:0] d;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         push_or_pop();
      end else if (r < 40) begin
         if (g_depth > 0) issue(OP_POP, $urandom); else push_or_pop();
      end else if (r < 60) begin
         case ($urandom_range(0, 7))
            0: issue(OP_ADD, $urandom);
            1: issue(OP_SUB, $urandom);
            2: issue(OP_MUL, $urandom);
            3: issue(OP_AND, $urandom);
            4: issue(OP_OR, $urandom);
            5: issue(OP_XOR, $urandom);
            6: issue(OP_EQU, $urandom);
            default: issue(OP_NEQU, $urandom);
         endcase
      end else if (r < 66) begin
         if (g_depth > 250) push_or_pop();
         else begin
            if ($urandom_range(0, 5) == 0) begin
               issue(OP_PUSH, 32'h8000_0000);
               d = 32'hFFFF_FFFF;
            end else begin
               do d = rand_word(); while (d == 0);
            end
            issue(OP_PUSH, d);
            issue($urandom_range(0, 1) ? OP_DIV : OP_MOD, $urandom);
         end
      end else if (r < 72) begin
         if (g_depth > 0 && g_depth < 256) issue(OP_DUP, $urandom); else push_or_pop();
      end else if (r < 77) begin
         if (g_depth >= 2) issue(OP_SWAP, $urandom); else push_or_pop();
      end else if (r < 81) begin
         if (g_depth > 0) issue(OP_NOT, $urandom); else push_or_pop();
      end else if (r < 86) begin
         if (g_calls.size() < CALL_DEPTH_DEF) begin
            if ($urandom_range(0, 1)) issue(OP_CALL, rel_target());
            else issue(OP_ACALL, WORD_W'($urandom_range(0, 60000)));
         end else issue(OP_RET, $urandom);
      end else if (r < 90) begin
         if (g_calls.size() > 0) issue(OP_RET, $urandom); else push_or_pop();
      end else if (r < 94) begin
         issue(OP_JMP, rel_target());
      end else begin
         if (g_depth >= 256) push_or_pop();
         else begin
            issue(OP_PUSH, $urandom_range(0, 1) ? '0 : rand_word());
            issue(OP_JNZ, rel_target());
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short binaries, wraps, signed division corners and control flow
      issue(OP_ADD, '0);
      issue(OP_PUSH, 32'h7FFF_FFFF);
      issue(OP_SUB, '1);
      issue(OP_PUSH, 32'h8000_0000);
      issue(OP_ADD, '0);
      issue(OP_PUSH, 32'h8000_0000);
      issue(OP_PUSH, 32'hFFFF_FFFF);
      issue(OP_DIV, '0);
      issue(OP_PUSH, 32'hFFFF_FFF9);
      issue(OP_PUSH, 32'd2);
      issue(OP_MOD, '0);
      issue(OP_PUSH, 32'h8000_0000);
      issue(OP_PUSH, 32'hFFFF_FFFF);
      issue(OP_MOD, '0);
      issue(OP_MUL, '0);
      issue(OP_DUP, '0);
      issue(OP_SWAP, '0);
      issue(OP_NOT, '0);
      issue(OP_EQU, '0);
      issue(OP_CALL, 32'd3);
      issue(OP_ACALL, 32'd60000);
      issue(OP_RET, '0);
      issue(OP_RET, '0);
      issue(OP_PUSH, '0);
      issue(OP_JNZ, 32'd9);

      for (int i = 0; i < 1300; i++) begin
         if (i % 150 == 0) quiet = ~quiet;
         if (i == 600) begin
            // hold until the block has drained
            req_valid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
         if (i == 800) while (g_depth < DATA_DEPTH_DEF) issue(OP_PUSH, $urandom);
         random_step();
      end
      quiet = 1'b0;

      // end on one fault, then show that further requests are ignored
      fault_pick = $urandom_range(0, 7);
      case (fault_pick)
         0: issue(OP_HALT, $urandom);
         1: send(OP_ADD + 8'($urandom_range(18, 235)), $urandom);
         2: begin
            if (g_depth >= DATA_DEPTH_DEF) issue(OP_POP, '0);
            issue(OP_PUSH, '0);
            issue(OP_DIV, '0);
         end
         3: issue(OP_JMP, WORD_W'(-g_pc - 1));
         4: begin
            while (g_calls.size() > 0) issue(OP_RET, '0);
            issue(OP_RET, '0);
         end
         5: begin
            while (g_depth > 0) issue(OP_POP, '0);
            issue(OP_POP, '0);
         end
         6: begin
            while (g_calls.size() < CALL_DEPTH_DEF) issue(OP_ACALL, 32'd100);
            issue(OP_ACALL, 32'd100);
         end
         default: begin
            while (g_depth < DATA_DEPTH_DEF) issue(OP_PUSH, $urandom);
            issue(OP_PUSH, '0);
         end
      endcase
      for (int i = 0; i < 24; i++) send(8'($urandom_range(0, 255)), $urandom);
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (60) @(posedge clock);
      $display("ran %0d requests, %0d responses checked, data stack peak %0d",
               sent, responses, max_depth_seen);
      $display("final fault scenario %0d, followed by requests after the stop", fault_pick);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
